>>> src/pidw_pkg.sv
// ============================================================================
// pidw_pkg
// Shared widths, constants, register codes and status types of the PID core.
// ============================================================================
package pidw_pkg;

    localparam int ERR_W     = 32;   // error, integral, derivative, control
    localparam int DT_W      = 32;   // time step, Q8.24
    localparam int GAIN_W    = 48;   // Q8.40 gains
    localparam int LIM_W     = 15;   // windup limit in whole units
    localparam int PWM_W     = 28;   // Q12.16 PWM level
    localparam int FLAG_W    = 2;
    localparam int FRAC_W    = 16;   // fraction bits of Q16.16
    localparam int ACC_W     = 42;   // term sums and the unclamped integral

    localparam int ADDR_W    = 5;
    localparam int DATA_W    = 64;

    // serial multiplier: one multiplier bit per cycle
    localparam int MUL_STEPS = ERR_W;
    localparam int MUL_P_W   = GAIN_W + 1;
    localparam int MUL_LO_W  = 8;    // product bits 31..24, kept for the Q24 shift

    // serial divider: (diff << 24) / dt, one quotient bit per cycle
    localparam int DIV_SHIFT = 24;
    localparam int DIV_BITS  = ERR_W + 1 + DIV_SHIFT;

    localparam logic [PWM_W-1:0] PWM_MIN = 28'd127795200;  // 1950.0
    localparam logic [PWM_W-1:0] PWM_MAX = 28'd147456000;  // 2250.0

    localparam logic signed [ERR_W-1:0] I32_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [ERR_W-1:0] I32_MIN = 32'sh8000_0000;

    localparam logic [FLAG_W-1:0] FLAG_NONE = 2'd0;
    localparam logic [FLAG_W-1:0] FLAG_LOW  = 2'd1;
    localparam logic [FLAG_W-1:0] FLAG_HIGH = 2'd2;

    localparam logic [1:0] REG_PROP_GAIN  = 2'd0;
    localparam logic [1:0] REG_INTEG_GAIN = 2'd1;
    localparam logic [1:0] REG_DERIV_GAIN = 2'd2;
    localparam logic [1:0] REG_WINDUP     = 2'd3;

    localparam logic signed [GAIN_W-1:0] PROP_GAIN_RST  = 48'sd25288767439;
    localparam logic signed [GAIN_W-1:0] INTEG_GAIN_RST = 48'sd4398046511;
    localparam logic signed [GAIN_W-1:0] DERIV_GAIN_RST = 48'sd219902;
    localparam logic [LIM_W-1:0]         WINDUP_RST     = 15'd200;

    typedef struct packed {
        logic busy;
        logic done;
    } t_unit_stat;

endpackage

>>> src/pidw_mul.sv
// ============================================================================
// pidw_mul
// Bit-serial signed multiplier: 48-bit multiplicand by 32-bit multiplier.
// ============================================================================
module pidw_mul import pidw_pkg::*; (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    input  logic signed [GAIN_W-1:0]   i_mcand,
    input  logic signed [ERR_W-1:0]    i_mplier,
    output t_unit_stat                 o_stat,
    output logic signed [MUL_P_W-1:0]  o_prod_hi,  // product bits 80..32
    output logic [MUL_LO_W-1:0]        o_prod_lo   // product bits 31..24
);

    localparam int CNT_W = $clog2(MUL_STEPS);

    logic                      r_busy, n_busy;
    logic                      r_done, n_done;
    logic [CNT_W-1:0]          r_cnt, n_cnt;
    logic signed [GAIN_W-1:0]  r_mcand, n_mcand;
    logic [ERR_W-1:0]          r_x, n_x;
    logic signed [MUL_P_W-1:0] r_p, n_p;
    logic [MUL_LO_W-1:0]       r_lo, n_lo;

    logic signed [MUL_P_W:0]   v_g;
    logic signed [MUL_P_W:0]   v_add;
    logic signed [MUL_P_W:0]   v_sum;
    logic                      v_last;

    always_comb begin
        v_last = (r_cnt == CNT_W'(MUL_STEPS - 1));
        v_g    = (MUL_P_W + 1)'(r_mcand);
        // sign bit of the multiplier weighs -2^31: subtract on the last step
        if (!r_x[0]) begin
            v_add = '0;
        end else if (v_last) begin
            v_add = -v_g;
        end else begin
            v_add = v_g;
        end
        v_sum = (MUL_P_W + 1)'(r_p) + v_add;

        n_busy  = r_busy;
        n_done  = 1'b0;
        n_cnt   = r_cnt;
        n_mcand = r_mcand;
        n_x     = r_x;
        n_p     = r_p;
        n_lo    = r_lo;
        if (i_start && !r_busy) begin
            n_busy  = 1'b1;
            n_cnt   = '0;
            n_mcand = i_mcand;
            n_x     = i_mplier;
            n_p     = '0;
        end else if (r_busy) begin
            // shift right one place, catch the dropped bit
            n_p   = v_sum[MUL_P_W:1];
            n_lo  = {v_sum[0], r_lo[MUL_LO_W-1:1]};
            n_x   = {1'b0, r_x[ERR_W-1:1]};
            n_cnt = r_cnt + 1'b1;
            if (v_last) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        r_mcand <= n_mcand;
        r_x     <= n_x;
        r_p     <= n_p;
        r_lo    <= n_lo;
    end

    assign o_stat.busy = r_busy;
    assign o_stat.done = r_done;
    assign o_prod_hi   = r_p;
    assign o_prod_lo   = r_lo;

endmodule

>>> src/pidw_div.sv
// ============================================================================
// pidw_div
// Bit-serial restoring divider for the derivative, saturated to 32 bits.
// ============================================================================
module pidw_div import pidw_pkg::*; (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_start,
    input  logic [ERR_W:0]           i_mag,   // |error difference|
    input  logic                     i_neg,
    input  logic [DT_W-1:0]          i_dt,
    output t_unit_stat               o_stat,
    output logic signed [ERR_W-1:0]  o_quot
);

    localparam int CNT_W = $clog2(DIV_BITS);

    logic                r_busy, n_busy;
    logic                r_done, n_done;
    logic [CNT_W-1:0]    r_cnt, n_cnt;
    logic [DT_W-1:0]     r_rem, n_rem;
    logic [DIV_BITS-1:0] r_quo, n_quo;
    logic [DT_W-1:0]     r_dt, n_dt;
    logic                r_neg, n_neg;

    logic [DT_W:0]       v_trial;
    logic [DT_W+1:0]     v_diff;
    logic                v_ge;
    logic                v_pos_ovf;
    logic                v_neg_ovf;

    always_comb begin
        v_trial = {r_rem, r_quo[DIV_BITS-1]};
        v_diff  = {1'b0, v_trial} - {2'b00, r_dt};
        v_ge    = !v_diff[DT_W+1];

        n_busy = r_busy;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        n_rem  = r_rem;
        n_quo  = r_quo;
        n_dt   = r_dt;
        n_neg  = r_neg;
        if (i_start && !r_busy) begin
            n_busy = 1'b1;
            n_cnt  = '0;
            n_rem  = '0;
            n_quo  = {i_mag, {DIV_SHIFT{1'b0}}};
            n_dt   = i_dt;
            n_neg  = i_neg;
        end else if (r_busy) begin
            // dividend bits leave at the top, quotient bits enter at the bottom
            n_rem = v_ge ? v_diff[DT_W-1:0] : v_trial[DT_W-1:0];
            n_quo = {r_quo[DIV_BITS-2:0], v_ge};
            n_cnt = r_cnt + 1'b1;
            if (r_cnt == CNT_W'(DIV_BITS - 1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        r_rem <= n_rem;
        r_quo <= n_quo;
        r_dt  <= n_dt;
        r_neg <= n_neg;
    end

    // negative side reaches one step further than the positive side
    assign v_pos_ovf = |r_quo[DIV_BITS-1:ERR_W-1];
    assign v_neg_ovf = (|r_quo[DIV_BITS-1:ERR_W])
                       || (r_quo[ERR_W-1] && (|r_quo[ERR_W-2:0]));

    always_comb begin
        if (r_neg) begin
            o_quot = v_neg_ovf ? I32_MIN : -$signed(r_quo[ERR_W-1:0]);
        end else begin
            o_quot = v_pos_ovf ? I32_MAX : $signed(r_quo[ERR_W-1:0]);
        end
    end

    assign o_stat.busy = r_busy;
    assign o_stat.done = r_done;

endmodule

>>> src/pid_with_windup_and_pwm_clamp_core.sv
// ============================================================================
// pid_with_windup_and_pwm_clamp_core
// PID step with integral windup clamp and a clamped PWM level accumulator.
// ============================================================================
// One word in (error Q16.16, time step Q8.24) gives one word out (control
// Q16.16, PWM level Q12.16, windup flag). The block works on one word at a
// time: a word makes four passes through the single bit-serial multiplier
// (error*dt, then the proportional, integral and derivative products), each
// started from a launch state and retired from a wait state, and then goes
// through a saturation state and a PWM update state before the next word can
// be accepted. The serial divider for the derivative runs beside the first
// two passes. A finished word sits in the output register, so the
// next input word is accepted while it waits; a new result is held back only
// until that register is taken. Gains and the windup limit sit on an APB
// port at byte addresses 0, 8, 16 and 24 and must be written while idle.
module pid_with_windup_and_pwm_clamp_core import pidw_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_s_axis_tvalid,
    output logic              o_s_axis_tready,
    input  logic [63:0]       i_s_axis_tdata,   // error_in[31:0], step_time[63:32]
    output logic              o_m_axis_tvalid,
    input  logic              i_m_axis_tready,
    output logic [63:0]       o_m_axis_tdata,   // control_out[31:0], pwm_level[59:32]
    output logic [FLAG_W-1:0] o_m_axis_tuser,   // windup_flag[1:0]
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready
);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_LAUNCH = 3'd1;
    localparam logic [2:0] S_WAIT   = 3'd2;
    localparam logic [2:0] S_SAT    = 3'd3;
    localparam logic [2:0] S_FIN    = 3'd4;

    localparam logic [1:0] PH_INTEG = 2'd0;
    localparam logic [1:0] PH_PROP  = 2'd1;
    localparam logic [1:0] PH_IGAIN = 2'd2;
    localparam logic [1:0] PH_DGAIN = 2'd3;

    localparam int PWM_SUM_W = ERR_W + 2;

    // configuration
    logic signed [GAIN_W-1:0] r_prop_gain, n_prop_gain;
    logic signed [GAIN_W-1:0] r_integ_gain, n_integ_gain;
    logic signed [GAIN_W-1:0] r_deriv_gain, n_deriv_gain;
    logic [LIM_W-1:0]         r_windup, n_windup;

    // controller state
    logic signed [ERR_W-1:0]  r_integ_acc, n_integ_acc;
    logic signed [ERR_W-1:0]  r_last_err, n_last_err;
    logic [PWM_W-1:0]         r_pwm_acc, n_pwm_acc;

    // work registers
    logic [2:0]               r_state, n_state;
    logic [1:0]               r_phase, n_phase;
    logic signed [ERR_W-1:0]  r_err, n_err;
    logic [DT_W-1:0]          r_dt, n_dt;
    logic signed [ERR_W-1:0]  r_deriv, n_deriv;
    logic signed [ACC_W-1:0]  r_sum, n_sum;
    logic signed [ERR_W-1:0]  r_ctl, n_ctl;
    logic [FLAG_W-1:0]        r_flag, n_flag;

    // output word
    logic                     r_out_vld, n_out_vld;
    logic signed [ERR_W-1:0]  r_out_ctl, n_out_ctl;
    logic [PWM_W-1:0]         r_out_pwm, n_out_pwm;
    logic [FLAG_W-1:0]        r_out_flag, n_out_flag;

    // units
    t_unit_stat               mul_stat, div_stat;
    logic                     mul_start, div_start;
    logic signed [GAIN_W-1:0] mul_mcand;
    logic signed [ERR_W-1:0]  mul_mplier;
    logic signed [MUL_P_W-1:0] mul_hi;
    logic [MUL_LO_W-1:0]      mul_lo;
    logic signed [ERR_W-1:0]  div_quot;

    logic                     cfg_wr;
    logic [1:0]               cfg_idx;
    logic                     in_acc;
    logic [ERR_W:0]           v_diff;
    logic                     v_diff_neg;
    logic [ERR_W:0]           v_diff_mag;
    logic signed [ACC_W-1:0]  v_term;
    logic signed [ACC_W-1:0]  v_isum;
    logic signed [ACC_W-1:0]  v_lim;
    logic signed [PWM_SUM_W-1:0] v_pwm;

    assign cfg_wr  = psel && penable && pwrite && pready;
    assign cfg_idx = paddr[ADDR_W-1:3];
    assign pready  = 1'b1;

    always_comb begin
        unique case (cfg_idx)
            REG_PROP_GAIN:  prdata = DATA_W'(unsigned'(r_prop_gain));
            REG_INTEG_GAIN: prdata = DATA_W'(unsigned'(r_integ_gain));
            REG_DERIV_GAIN: prdata = DATA_W'(unsigned'(r_deriv_gain));
            REG_WINDUP:     prdata = DATA_W'(r_windup);
        endcase
    end

    assign in_acc          = i_s_axis_tvalid && o_s_axis_tready;
    assign o_s_axis_tready = (r_state == S_IDLE);

    // derivative operands: sign and magnitude of error - last error
    assign v_diff     = {r_err[ERR_W-1], r_err} - {r_last_err[ERR_W-1], r_last_err};
    assign v_diff_neg = v_diff[ERR_W];
    assign v_diff_mag = v_diff_neg ? -v_diff : v_diff;

    assign div_start = (r_state == S_LAUNCH) && (r_phase == PH_INTEG);
    assign mul_start = (r_state == S_LAUNCH) && !mul_stat.busy
                       && !((r_phase == PH_DGAIN) && div_stat.busy);

    always_comb begin
        unique case (r_phase)
            PH_INTEG: begin
                mul_mcand  = signed'(GAIN_W'(r_dt));
                mul_mplier = r_err;
            end
            PH_PROP: begin
                mul_mcand  = r_prop_gain;
                mul_mplier = r_err;
            end
            PH_IGAIN: begin
                mul_mcand  = r_integ_gain;
                mul_mplier = r_integ_acc;
            end
            PH_DGAIN: begin
                mul_mcand  = r_deriv_gain;
                mul_mplier = r_deriv;
            end
        endcase
    end

    pidw_mul u_mul (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (mul_start),
        .i_mcand   (mul_mcand),
        .i_mplier  (mul_mplier),
        .o_stat    (mul_stat),
        .o_prod_hi (mul_hi),
        .o_prod_lo (mul_lo)
    );

    pidw_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_mag   (v_diff_mag),
        .i_neg   (v_diff_neg),
        .i_dt    (r_dt),
        .o_stat  (div_stat),
        .o_quot  (div_quot)
    );

    // floor(gain * x / 2^40) is the high product part shifted down by eight
    assign v_term = ACC_W'(signed'(mul_hi[MUL_P_W-1:8]));
    // integral step: floor(err * dt / 2^24), then add to the accumulator
    assign v_isum = ACC_W'(signed'({mul_hi, mul_lo})) + ACC_W'(r_integ_acc);
    assign v_lim  = signed'({{(ACC_W-LIM_W-FRAC_W){1'b0}}, r_windup, {FRAC_W{1'b0}}});
    assign v_pwm  = signed'(PWM_SUM_W'(r_pwm_acc)) + PWM_SUM_W'(r_ctl);

    always_comb begin
        n_prop_gain  = r_prop_gain;
        n_integ_gain = r_integ_gain;
        n_deriv_gain = r_deriv_gain;
        n_windup     = r_windup;
        n_integ_acc  = r_integ_acc;
        n_last_err   = r_last_err;
        n_pwm_acc    = r_pwm_acc;
        n_state      = r_state;
        n_phase      = r_phase;
        n_err        = r_err;
        n_dt         = r_dt;
        n_deriv      = r_deriv;
        n_sum        = r_sum;
        n_ctl        = r_ctl;
        n_flag       = r_flag;
        n_out_vld    = r_out_vld && !i_m_axis_tready;
        n_out_ctl    = r_out_ctl;
        n_out_pwm    = r_out_pwm;
        n_out_flag   = r_out_flag;

        if (cfg_wr) begin
            unique case (cfg_idx)
                REG_PROP_GAIN:  n_prop_gain  = signed'(pwdata[GAIN_W-1:0]);
                REG_INTEG_GAIN: n_integ_gain = signed'(pwdata[GAIN_W-1:0]);
                REG_DERIV_GAIN: n_deriv_gain = signed'(pwdata[GAIN_W-1:0]);
                REG_WINDUP:     n_windup     = pwdata[LIM_W-1:0];
            endcase
        end

        if (div_stat.done) begin
            n_deriv = (r_dt == '0) ? '0 : div_quot;
        end

        unique case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    n_err   = signed'(i_s_axis_tdata[ERR_W-1:0]);
                    n_dt    = i_s_axis_tdata[ERR_W +: DT_W];
                    n_phase = PH_INTEG;
                    n_sum   = '0;
                    n_state = S_LAUNCH;
                end
            end
            S_LAUNCH: begin
                if (mul_start) begin
                    n_state = S_WAIT;
                end
            end
            S_WAIT: begin
                if (mul_stat.done) begin
                    n_phase = r_phase + 1'b1;
                    n_state = S_LAUNCH;
                    unique case (r_phase)
                        PH_INTEG: begin
                            priority if (v_isum < -v_lim) begin
                                n_integ_acc = ERR_W'(-v_lim);
                                n_flag      = FLAG_LOW;
                            end else if (v_isum > v_lim) begin
                                n_integ_acc = ERR_W'(v_lim);
                                n_flag      = FLAG_HIGH;
                            end else begin
                                n_integ_acc = ERR_W'(v_isum);
                                n_flag      = FLAG_NONE;
                            end
                        end
                        PH_PROP, PH_IGAIN: begin
                            n_sum = r_sum + v_term;
                        end
                        PH_DGAIN: begin
                            n_sum   = r_sum + v_term;
                            n_state = S_SAT;
                        end
                    endcase
                end
            end
            S_SAT: begin
                priority if (r_sum > ACC_W'(I32_MAX)) begin
                    n_ctl = I32_MAX;
                end else if (r_sum < ACC_W'(I32_MIN)) begin
                    n_ctl = I32_MIN;
                end else begin
                    n_ctl = ERR_W'(r_sum);
                end
                n_state = S_FIN;
            end
            S_FIN: begin
                // hold until the output register is free
                if (!r_out_vld || i_m_axis_tready) begin
                    priority if (v_pwm > signed'(PWM_SUM_W'(PWM_MAX))) begin
                        n_pwm_acc = PWM_MAX;
                    end else if (v_pwm < signed'(PWM_SUM_W'(PWM_MIN))) begin
                        n_pwm_acc = PWM_MIN;
                    end else begin
                        n_pwm_acc = PWM_W'(v_pwm);
                    end
                    n_out_pwm  = n_pwm_acc;
                    n_out_ctl  = r_ctl;
                    n_out_flag = r_flag;
                    n_out_vld  = 1'b1;
                    n_last_err = r_err;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prop_gain  <= PROP_GAIN_RST;
            r_integ_gain <= INTEG_GAIN_RST;
            r_deriv_gain <= DERIV_GAIN_RST;
            r_windup     <= WINDUP_RST;
            r_integ_acc  <= '0;
            r_last_err   <= '0;
            r_pwm_acc    <= PWM_MIN;
            r_state      <= S_IDLE;
            r_phase      <= PH_INTEG;
            r_out_vld    <= 1'b0;
        end else begin
            r_prop_gain  <= n_prop_gain;
            r_integ_gain <= n_integ_gain;
            r_deriv_gain <= n_deriv_gain;
            r_windup     <= n_windup;
            r_integ_acc  <= n_integ_acc;
            r_last_err   <= n_last_err;
            r_pwm_acc    <= n_pwm_acc;
            r_state      <= n_state;
            r_phase      <= n_phase;
            r_out_vld    <= n_out_vld;
        end
        r_err      <= n_err;
        r_dt       <= n_dt;
        r_deriv    <= n_deriv;
        r_sum      <= n_sum;
        r_ctl      <= n_ctl;
        r_flag     <= n_flag;
        r_out_ctl  <= n_out_ctl;
        r_out_pwm  <= n_out_pwm;
        r_out_flag <= n_out_flag;
    end

    assign o_m_axis_tvalid = r_out_vld;
    assign o_m_axis_tdata  = {{(64 - ERR_W - PWM_W){1'b0}}, r_out_pwm, r_out_ctl};
    assign o_m_axis_tuser  = r_out_flag;

endmodule

>>> src/pidw_chk.sv
// ============================================================================
// pidw_chk
// Port-level checks of the PID core, bound to the top level.
// ============================================================================
module pidw_chk import pidw_pkg::*; (
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              i_s_axis_tvalid,
    input logic              o_s_axis_tready,
    input logic              o_m_axis_tvalid,
    input logic              i_m_axis_tready,
    input logic [63:0]       o_m_axis_tdata,
    input logic [FLAG_W-1:0] o_m_axis_tuser
);

    // a stalled result word holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=>
            o_m_axis_tvalid && $stable(o_m_axis_tdata) && $stable(o_m_axis_tuser))
        else $error("output word changed while stalled");

    // PWM level stays inside its clamp range
    a_pwm_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |->
            (o_m_axis_tdata[59:32] >= PWM_MIN) && (o_m_axis_tdata[59:32] <= PWM_MAX))
        else $error("pwm level outside clamp range");

    // windup flag only names no clamp, low or high
    a_flag_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |->
            (o_m_axis_tuser == FLAG_NONE) || (o_m_axis_tuser == FLAG_LOW)
            || (o_m_axis_tuser == FLAG_HIGH))
        else $error("bad windup flag");

    // one word at a time: input closes right after an accept
    a_one_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_axis_tvalid && o_s_axis_tready |=> !o_s_axis_tready)
        else $error("input accepted while a word is in work");

endmodule

bind pid_with_windup_and_pwm_clamp_core pidw_chk u_pidw_chk (.*);
